// ===== hdl/stereo_linear_resampler_unit_assert.svh =====
// Assertion macros shared by the resampler RTL.
`ifndef STEREO_LINEAR_RESAMPLER_UNIT_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SLRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler check failed");

`else

`define SLRU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/slr_pkg.sv =====
package slr_pkg;

  localparam int STEP_W = 19;
  localparam logic [STEP_W-1:0] STEP_MIN = 19'd4096;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Configuration register indexes.
  localparam logic CFG_STEP_RATIO = 1'b0;
  localparam logic CFG_ENABLE     = 1'b1;

  typedef struct packed {
    logic load;
    logic emit;
    logic finish;
  } slr_cmd_t;

  typedef struct packed {
    logic phase_ge_one;
    logic sum_ge_one;
  } slr_status_t;

endpackage

// ===== hdl/slr_ctrl.sv =====
module slr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 enable,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  slr_pkg::slr_status_t status,
  output slr_pkg::slr_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        // A frame taken while disabled is simply dropped.
        if (in_valid && enable) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.phase_ge_one) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.sum_ge_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/slr_datapath.sv =====
module slr_datapath #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [15:0]            in_sample_left,
  input  logic signed [15:0]            in_sample_right,
  input  logic [slr_pkg::STEP_W-1:0]    step_ratio,
  input  slr_pkg::slr_cmd_t             cmd,
  output slr_pkg::slr_status_t          status,
  output logic signed [15:0]            out_left,
  output logic signed [15:0]            out_right,
  output logic                          out_last_of_run
);

  localparam int F  = PHASE_FRAC_BITS;
  localparam int PW = F + 4;
  localparam int AW = F + 3;
  localparam int WW = F + slr_pkg::STEP_W;
  localparam int NW = F + 19;
  localparam logic [PW-1:0] ONE = PW'(1) << F;

  logic [PW-1:0]         phase_r;
  logic signed [15:0]    prev_left_r, prev_right_r;
  logic signed [15:0]    new_left_r, new_right_r;
  logic signed [15:0]    out_left_r, out_right_r;
  logic                  out_last_r;

  logic [slr_pkg::STEP_W-1:0] step_cl;
  logic [WW-1:0]              step_wide;
  logic [AW-1:0]              step_al;
  logic [PW-1:0]              sum;

  // prev + (next - prev) * ph, truncated toward zero and saturated.
  function automatic logic signed [15:0] interp(input logic signed [15:0] p,
                                                input logic signed [15:0] n,
                                                input logic [F-1:0] ph);
    logic signed [16:0]   diff;
    logic signed [NW-1:0] prod;
    logic signed [NW-1:0] num;
    logic signed [NW-1:0] q;
    diff = $signed({n[15], n}) - $signed({p[15], p});
    prod = NW'(diff) * NW'($signed({1'b0, ph}));
    num  = (NW'(p) <<< F) + prod;
    if (num[NW-1]) begin
      q = (num + $signed(NW'({F{1'b1}}))) >>> F;
    end else begin
      q = num >>> F;
    end
    if (q > NW'(slr_pkg::SAMPLE_MAX)) begin
      q = NW'(slr_pkg::SAMPLE_MAX);
    end else if (q < NW'(slr_pkg::SAMPLE_MIN)) begin
      q = NW'(slr_pkg::SAMPLE_MIN);
    end
    return $signed(q[15:0]);
  endfunction

  // Clamp the step, then align Q3.16 to the phase fraction width.
  assign step_cl   = (step_ratio < slr_pkg::STEP_MIN) ? slr_pkg::STEP_MIN : step_ratio;
  assign step_wide = WW'(step_cl) << F;
  assign step_al   = step_wide[WW-1:16];
  assign sum       = phase_r + PW'(step_al);

  assign status.phase_ge_one = |phase_r[PW-1:F];
  assign status.sum_ge_one   = |sum[PW-1:F];

  assign out_left        = out_left_r;
  assign out_right       = out_right_r;
  assign out_last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
    end else begin
      if (cmd.finish) begin
        phase_r      <= phase_r - ONE;
        prev_left_r  <= new_left_r;
        prev_right_r <= new_right_r;
      end else if (cmd.emit) begin
        if (status.sum_ge_one) begin
          phase_r      <= sum - ONE;
          prev_left_r  <= new_left_r;
          prev_right_r <= new_right_r;
        end else begin
          phase_r <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_left_r  <= in_sample_left;
      new_right_r <= in_sample_right;
    end
    if (cmd.emit) begin
      out_left_r  <= interp(prev_left_r, new_left_r, phase_r[F-1:0]);
      out_right_r <= interp(prev_right_r, new_right_r, phase_r[F-1:0]);
      out_last_r  <= status.sum_ge_one;
    end
  end

endmodule

// ===== hdl/stereo_linear_resampler_unit.sv =====
// Stereo linear-interpolation resampler.
// Input channel (in_valid / in_stall) carries one signed 16-bit stereo frame per item;
// in_end_of_batch is carried for the source side and does not affect the results.
// Result channel (out_valid / out_stall) carries interpolated frames; out_last_of_run
// marks the final result caused by one input frame.
// The configuration port takes step_ratio (index 0, unsigned Q3.16 phase increment) and
// enable (index 1); the user must write them only while the block is idle (unenforced).
// An accepted frame is registered and the control moves to its run state, where each
// result is interpolated into the output register, from which it can be taken. Results come
// one per cycle while the receiver does not stall, from one interpolator per channel; a
// frame whose phase is already one or more is finished without results. At most 16 results
// per frame.
// The input is stalled while a frame is being worked on; the next frame can be taken
// while its last result still waits in the output register.
// When the receiver stalls, the output register holds its item and interpolation
// pauses until it is taken.
// Reset (synchronous, rst_n low) clears phase and previous frame to zero, sets
// step_ratio to one and disables the block.
`include "stereo_linear_resampler_unit_assert.svh"

module stereo_linear_resampler_unit #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         in_sample_left,
  input  logic signed [15:0]         in_sample_right,
  input  logic                       in_end_of_batch,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [15:0]         out_left,
  output logic signed [15:0]         out_right,
  output logic                       out_last_of_run,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [slr_pkg::STEP_W-1:0] cfg_data
);

  logic [slr_pkg::STEP_W-1:0] step_ratio_r;
  logic                       enable_r;
  slr_pkg::slr_cmd_t          cmd;
  slr_pkg::slr_status_t       status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ratio_r <= slr_pkg::STEP_W'(65536);
      enable_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slr_pkg::CFG_STEP_RATIO: step_ratio_r <= cfg_data;
        slr_pkg::CFG_ENABLE:     enable_r     <= cfg_data[0];
      endcase
    end
  end

  slr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .enable    (enable_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  slr_datapath #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .step_ratio      (step_ratio_r),
    .cmd             (cmd),
    .status          (status),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last_of_run (out_last_of_run)
  );

  `SLRU_ASSERT_NEXT(a_busy_after_enabled_item, clk, rst_n, in_valid && !in_stall && enable_r, in_stall)
  `SLRU_ASSERT_NEXT(a_idle_after_dropped_item, clk, rst_n, in_valid && !in_stall && !enable_r, !in_stall)
  `SLRU_ASSERT_NOW(a_no_emit_over_held_item, clk, rst_n, out_valid && out_stall, !cmd.emit)
  `SLRU_ASSERT_NOW(a_no_emit_when_idle, clk, rst_n, !in_stall, !cmd.emit && !cmd.finish)

endmodule
